FILE: hw/rtl/sidta_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the signed integer to decimal ascii converter
// no dependencies
`default_nettype none

package sidta_pkg;

   localparam int DIGIT_BITS = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // character emitter states
   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SKIP,
      EMIT_SIGN,
      EMIT_DIGIT
   } emit_state_type;

   // status of the converter towards the emitter
   typedef struct packed {
      logic done;
      logic negative;
   } conv_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// top level of the signed integer to decimal ascii converter
// depends on sidta_pkg, sidta_dabble and sidta_emit
`default_nettype none

// Converts one signed two's complement word of VALUE_BITS bits into its
// decimal text, sent one ascii character per rsp word, most significant
// first: a leading '-' for negative values, no leading zeros, a single '0'
// for zero, and rsp_is_last high on the final character. The most negative
// value converts correctly. Text longer than MAX_CHARS is cut to its first
// MAX_CHARS characters, the last of them flagged. A word taken on req goes
// into a bit serial shift-and-add-three converter and is handed over once
// the emitter is idle; the emitter loads it, skips leading zeros, then
// sends the sign and digits as the consumer takes them, while the converter
// already works on the next word. With a ready consumer the sustained rate
// is therefore set by the slower of the converter shift loop and the
// emitter. Nothing is kept between words.

module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_CHARS  = 11
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [7:0]                   rsp_char_code,
   output logic                         rsp_is_last
);

   // decimal digits of 2^(VALUE_BITS-1), using log10(2) ~ 1233/4096
   localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
   localparam int BCD_W      = NUM_DIGITS * sidta_pkg::DIGIT_BITS;

   sidta_pkg::conv_status_type conv_status;
   logic [BCD_W-1:0]           conv_bcd;
   logic                       req_take;
   logic                       emit_idle;
   logic                       handover;

   assign req_take = req_valid && req_ready;
   // converter result moves to the emitter once the converter is done and the emitter is idle
   assign handover = conv_status.done && emit_idle;

   sidta_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .clock    (clock),
      .reset    (reset),
      .load     (req_take),
      .value    (req_value),
      .take     (handover),
      .in_ready (req_ready),
      .status   (conv_status),
      .bcd      (conv_bcd)
   );

   sidta_emit #(
      .NUM_DIGITS (NUM_DIGITS),
      .MAX_CHARS  (MAX_CHARS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (handover),
      .negative      (conv_status.negative),
      .bcd           (conv_bcd),
      .idle          (emit_idle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("new word taken while converter busy");

   a_handover_frees: assert property (@(posedge clock) disable iff (reset)
      handover |=> req_ready && !emit_idle)
      else $error("handover did not move the number to the emitter");

   a_done_blocks_req: assert property (@(posedge clock) disable iff (reset)
      conv_status.done |-> !req_ready)
      else $error("req ready while a finished number waits");

endmodule

`default_nettype wire

FILE: hw/rtl/sidta_dabble.sv
`timescale 1ns / 1ps
// bit serial binary to bcd converter (shift and add three)
// depends on sidta_pkg
`default_nettype none

module sidta_dabble #(
   parameter int VALUE_BITS = 32,
   parameter int NUM_DIGITS = 10
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         load,
   input  wire  signed [VALUE_BITS-1:0]                value,
   input  wire                                         take,
   output logic                                        in_ready,
   output sidta_pkg::conv_status_type                  status,
   output logic [NUM_DIGITS*sidta_pkg::DIGIT_BITS-1:0] bcd
);

   localparam int BCD_W = NUM_DIGITS * sidta_pkg::DIGIT_BITS;
   localparam int CNT_W = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] shreg_ff, shreg_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      adj;
   logic [VALUE_BITS-1:0] mag;

   // magnitude of the most negative value still fits as unsigned
   assign mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      bcd_in   = bcd_ff;
      if (load) begin
         busy_in  = 1'b1;
         neg_in   = value[VALUE_BITS-1];
         cnt_in   = CNT_W'(VALUE_BITS - 1);
         shreg_in = mag;
         bcd_in   = '0;
      end else if (busy_ff) begin
         bcd_in   = {adj[BCD_W-2:0], shreg_ff[VALUE_BITS-1]};
         shreg_in = {shreg_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (take) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      shreg_ff <= shreg_in;
      bcd_ff   <= bcd_in;
   end

   assign in_ready        = !busy_ff && !done_ff;
   assign status.done     = done_ff;
   assign status.negative = neg_ff;
   assign bcd             = bcd_ff;

   a_not_busy_and_done: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("converter busy and done together");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && !done_ff)
      else $error("load did not start conversion");

   a_done_after_last_bit: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == '0) |=> done_ff)
      else $error("conversion did not finish after last bit");

endmodule

`default_nettype wire

FILE: hw/rtl/sidta_emit.sv
`timescale 1ns / 1ps
// character emitter: skips leading zeros, sends sign and digits one per cycle while rsp_ready is high
// depends on sidta_pkg
`default_nettype none

module sidta_emit #(
   parameter int NUM_DIGITS = 10,
   parameter int MAX_CHARS  = 11
) (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         load,
   input  wire                                         negative,
   input  wire  [NUM_DIGITS*sidta_pkg::DIGIT_BITS-1:0] bcd,
   output logic                                        idle,
   output logic                                        rsp_valid,
   input  wire                                         rsp_ready,
   output logic [7:0]                                  rsp_char_code,
   output logic                                        rsp_is_last
);

   localparam int BCD_W  = NUM_DIGITS * sidta_pkg::DIGIT_BITS;
   localparam int LIMIT  = (MAX_CHARS > 24) ? 24 : ((MAX_CHARS < 1) ? 1 : MAX_CHARS);
   localparam int LEFT_W = $clog2(NUM_DIGITS + 1);
   localparam int CNT_W  = $clog2(LIMIT + 1);

   sidta_pkg::emit_state_type state_ff, state_in;

   logic [BCD_W-1:0]  dig_ff, dig_in;
   logic              neg_ff, neg_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;
   logic              out_free;
   logic [3:0]        top_digit;
   logic              at_limit;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign top_digit = dig_ff[BCD_W-1 -: 4];
   assign at_limit  = (cnt_ff == CNT_W'(LIMIT - 1));

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      neg_in       = neg_ff;
      left_in      = left_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         sidta_pkg::EMIT_IDLE: begin
            if (load) begin
               dig_in   = bcd;
               neg_in   = negative;
               left_in  = LEFT_W'(NUM_DIGITS);
               cnt_in   = '0;
               state_in = sidta_pkg::EMIT_SKIP;
            end
         end
         sidta_pkg::EMIT_SKIP: begin
            if (top_digit == 4'd0 && left_ff > LEFT_W'(1)) begin
               dig_in  = {dig_ff[BCD_W-5:0], 4'd0};
               left_in = left_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = sidta_pkg::EMIT_SIGN;
            end else begin
               state_in = sidta_pkg::EMIT_DIGIT;
            end
         end
         sidta_pkg::EMIT_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = sidta_pkg::CHAR_MINUS;
               out_last_in  = at_limit;
               cnt_in       = cnt_ff + 1'b1;
               state_in     = at_limit ? sidta_pkg::EMIT_IDLE : sidta_pkg::EMIT_DIGIT;
            end
         end
         sidta_pkg::EMIT_DIGIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = sidta_pkg::CHAR_ZERO + {4'd0, top_digit};
               out_last_in  = (left_ff == LEFT_W'(1)) || at_limit;
               dig_in       = {dig_ff[BCD_W-5:0], 4'd0};
               left_in      = left_ff - 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if ((left_ff == LEFT_W'(1)) || at_limit) begin
                  state_in = sidta_pkg::EMIT_IDLE;
               end
            end
         end
         default: begin
            state_in = sidta_pkg::EMIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sidta_pkg::EMIT_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      dig_ff      <= dig_in;
      neg_ff      <= neg_in;
      left_ff     <= left_in;
      cnt_ff      <= cnt_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign idle          = (state_ff == sidta_pkg::EMIT_IDLE);
   assign rsp_valid     = out_valid_ff;
   assign rsp_char_code = out_char_ff;
   assign rsp_is_last   = out_last_ff;

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_char_ff == sidta_pkg::CHAR_MINUS) ||
                       (out_char_ff >= sidta_pkg::CHAR_ZERO &&
                        out_char_ff <= sidta_pkg::CHAR_ZERO + 8'd9))
      else $error("illegal character code");

   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sidta_pkg::EMIT_DIGIT) |-> (left_ff != '0))
      else $error("digit state with no digits left");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !idle |-> (cnt_ff < CNT_W'(LIMIT)))
      else $error("character count past limit");

endmodule

`default_nettype wire

FILE: dv/decimal_text_checker.sv
`timescale 1ns / 1ps
// checker for the signed integer to decimal ascii converter: predicts the text
// of every accepted req word and compares each rsp word against it
// depends on sidta_pkg for the character constants

module decimal_text_checker #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_CHARS  = 11
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_ready,
   input  wire [VALUE_BITS-1:0] req_value,
   input  wire                  rsp_valid,
   input  wire                  rsp_ready,
   input  wire [7:0]            rsp_char_code,
   input  wire                  rsp_is_last,
   output int                   mismatch_count,
   output int                   pending_chars
);

   typedef struct {
      logic [7:0] char_code;
      logic       is_last;
   } text_char_type;

   text_char_type expected_text [$];
   text_char_type oldest_char;
   int            error_total = 0;

   // decimal text of one value, most significant character first
   function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] magnitude;
      logic [7:0]            text [$];
      text_char_type         next_char;
      int                    text_len;
      magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      do begin
         text.push_front(sidta_pkg::CHAR_ZERO + 8'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (value[VALUE_BITS-1])
         text.push_front(sidta_pkg::CHAR_MINUS);
      text_len = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
      for (int k = 0; k < text_len; k++) begin
         next_char.char_code = text[k];
         next_char.is_last   = (k == text_len - 1);
         expected_text.push_back(next_char);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_text.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected word: char_code %0d is_last %0d",
                      rsp_char_code, rsp_is_last);
               error_total++;
            end else begin
               oldest_char = expected_text.pop_front();
               if (rsp_char_code !== oldest_char.char_code) begin
                  $error("char_code: expected %0d, actual %0d",
                         oldest_char.char_code, rsp_char_code);
                  error_total++;
               end
               if (rsp_is_last !== oldest_char.is_last) begin
                  $error("is_last: expected %0d, actual %0d",
                         oldest_char.is_last, rsp_is_last);
                  error_total++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_text(req_value);
      end
      pending_chars  <= expected_text.size();
      mismatch_count <= error_total;
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// top of the converter testbench: clock, reset, req stimulus, rsp back-pressure,
// watchdog and verdict; depends on signed_int_to_decimal_ascii and decimal_text_checker

module testbench;

   localparam int VALUE_BITS = 32;
   localparam int MAX_CHARS  = 11;

   // percentages of cycles spent idle (sender) or stalling (receiver)
   localparam int IDLE_NONE  = 0;
   localparam int IDLE_HEAVY = 72;
   localparam int IDLE_BOTH  = 22;

   localparam int RANDOM_ITEMS = 188;
   localparam int PHASE_COUNT  = 4;

   // covers the converter shift loop plus the emitter's skipped zeros and
   // characters, so any trailing activity is caught with margin
   localparam int DRAIN_CYCLES = 3 * (VALUE_BITS + 2 * MAX_CHARS + 4);

   // slowest correct run per word: converter loop plus eleven characters each
   // behind a long receiver stall, plus a long sender gap; a quiet stretch
   // this long can only mean a hang
   localparam int WATCHDOG_LIMIT = 5000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [7:0]                   rsp_char_code;
   logic                         rsp_is_last;

   int mismatch_count;
   int pending_chars;

   // idling levels of the current phase, changed only at clock edges
   int send_idle_pct = IDLE_NONE;
   int recv_stall_pct = IDLE_NONE;

   int quiet_cycles = 0;

   signed_int_to_decimal_ascii #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_CHARS  (MAX_CHARS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

   decimal_text_checker #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_CHARS  (MAX_CHARS)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_code  (rsp_char_code),
      .rsp_is_last    (rsp_is_last),
      .mismatch_count (mismatch_count),
      .pending_chars  (pending_chars)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: ready drawn fresh every cycle, so stalls land on any character
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // offer one word, with a random idle gap first; valid stays high from one
   // word to the next when no gap is drawn
   task automatic send_word(input logic [VALUE_BITS-1:0] value);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // hold the sender off until every predicted character has come out
   task automatic drain_text();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_chars != 0)
         @(posedge clock);
   endtask

   // random value with a spread of text lengths: short numbers, mid sized,
   // full width noise and values hugging both extremes
   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] value;
      case ($urandom_range(4, 0))
         0: value = $urandom_range(99, 0);
         1: value = $urandom_range(999_999, 0);
         2: value = $urandom_range(32'h7fff_ffff, 32'h7fff_fff0);
         3: value = {1'b1, {(VALUE_BITS-1){1'b0}}} + $urandom_range(15, 0);
         default: value = $urandom;
      endcase
      // flip the sign of any non-negative value half the time
      if ($urandom_range(1, 0) && !value[VALUE_BITS-1])
         value = -value;
      return value;
   endfunction

   // watchdog: a stretch reaching WATCHDOG_LIMIT without a single handshake on either side fails
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner values, streamed back to back with a free-running receiver
      send_word(32'sd0);
      send_word(32'sd1);
      send_word(-32'sd1);
      send_word(32'sd9);
      send_word(32'sd10);
      send_word(-32'sd10);
      send_word(32'sd99);
      send_word(32'sd100);
      send_word(-32'sd101);
      send_word(32'sd999_999_999);
      send_word(-32'sd999_999_999);
      send_word(32'sd1_000_000_000);
      send_word(-32'sd1_000_000_000);
      send_word(32'sh7fff_ffff);        // largest positive: ten digits
      send_word(32'sh7fff_fffe);
      send_word(32'sh8000_0000);        // most negative: sign plus ten digits
      send_word(32'sh8000_0001);
      send_word(32'shffff_fff6);        // minus ten
      send_word(32'sh5555_5555);
      send_word(32'shaaaa_aaaa);

      // let the converter empty out completely once before the random part
      drain_text();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  <= IDLE_NONE;
               recv_stall_pct <= IDLE_NONE;
            end
            1: begin
               send_idle_pct  <= IDLE_HEAVY;
               recv_stall_pct <= IDLE_NONE;
            end
            2: begin
               send_idle_pct  <= IDLE_NONE;
               recv_stall_pct <= IDLE_HEAVY;
            end
            default: begin
               send_idle_pct  <= IDLE_BOTH;
               recv_stall_pct <= IDLE_BOTH;
            end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT + 1; n++)
            send_word(random_value());
         // second full drain in the middle of the run
         if (phase == 1)
            drain_text();
      end

      drain_text();
      // catch any stray words the block might still produce
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_chars == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
